[rtl/bvp_pkg.sv]
package bvp_pkg;

	localparam int unsigned DW   = 32;          // velocity and field words
	localparam int unsigned PW   = 64;          // full product
	localparam int unsigned XW   = PW + 1;      // product with room for negation
	localparam int unsigned SW   = 49;          // sum width ahead of a clamp
	localparam int unsigned KW   = 37;          // electric kick, kept wide
	localparam int unsigned DENW = 37;          // denominator 1 + |t|^2 in Q.28
	localparam int unsigned QW   = 33;          // quotient bits of s
	localparam int unsigned NW   = 61;          // dividend |t| * 2^29 + D/2
	localparam int unsigned FRAC = 28;
	localparam int unsigned AW   = 3;

	localparam logic REG_PUSH_FACTOR = 1'b0;

	localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

	typedef struct packed {
		logic signed [DW-1:0] val;
		logic                 ovf;
	} sat_t;

	// what rides alongside the divider
	typedef struct packed {
		logic                 ovf;
		logic [KW-1:0]        kick;
		logic [2:0][DW-1:0]   vm;
		logic [2:0][DW-1:0]   vo;
		logic [2:0]           neg;
	} side_t;

	typedef struct packed {
		logic [DENW-1:0]      den;
		logic [2:0][NW-1:0]   num;
		side_t                side;
	} divin_t;

	typedef struct packed {
		logic [2:0][QW-1:0]   quo;
		side_t                side;
	} divout_t;

	function automatic sat_t sat32(input logic signed [SW-1:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.val = SAT_MAX[DW-1:0];
			r.ovf = 1'b1;
		end else if (v < SAT_MIN) begin
			r.val = SAT_MIN[DW-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = v[DW-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// round to nearest, halves up, then drop n fraction bits
	function automatic logic signed [XW-1:0] rnd_sh(input logic signed [XW-1:0] x,
			input int unsigned n);
		logic signed [XW-1:0] half;
		half = XW'(65'sd1) <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	function automatic logic signed [XW-1:0] ext(input logic signed [PW-1:0] p);
		return $signed({p[PW-1], p});
	endfunction

endpackage

[rtl/bvp_front.sv]
module bvp_front import bvp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 mode,
	input  logic signed [DW-1:0] vel_x,
	input  logic signed [DW-1:0] vel_y,
	input  logic signed [DW-1:0] vel_z,
	input  logic signed [DW-1:0] field_e,
	input  logic signed [DW-1:0] mag_x,
	input  logic signed [DW-1:0] mag_y,
	input  logic signed [DW-1:0] mag_z,
	input  logic signed [DW-1:0] push_factor,
	output logic                 dout_valid,
	output divin_t               dout
);

	// stage 1: field products
	logic                 valid_s1, mode_s1;
	logic signed [DW-1:0] v_s1 [3];
	logic signed [PW-1:0] pk_s1;
	logic signed [PW-1:0] p_s1 [3];

	// stage 2: kick, t, first half kick
	logic                 valid_s2, ovf_s2;
	logic [KW-1:0]        kick_s2;
	logic signed [DW-1:0] vm_s2 [3];
	logic signed [DW-1:0] t_s2 [3];

	// stage 3: cross products and squares
	logic                 valid_s3, ovf_s3;
	logic [KW-1:0]        kick_s3;
	logic signed [DW-1:0] vm_s3 [3];
	logic signed [DW-1:0] t_s3 [3];
	logic signed [PW-1:0] ca_s3 [3];
	logic signed [PW-1:0] cb_s3 [3];
	logic signed [PW-1:0] sq_s3 [3];

	// stage 4: first rotation, |t|^2
	logic                 valid_s4, ovf_s4;
	logic [KW-1:0]        kick_s4;
	logic [2:0][DW-1:0]   vm_s4;
	logic [2:0][DW-1:0]   vo_s4;
	logic [2:0]           neg_s4;
	logic [DW-1:0]        mag_s4 [3];
	logic [PW-1:0]        sum_s4;

	logic signed [XW-1:0] kick_w;
	logic signed [XW-1:0] t_w [3];
	sat_t                 t_sat [3];
	sat_t                 vmx_sat;
	sat_t                 vo_sat [3];
	logic signed [XW-1:0] ra [3];
	logic signed [XW-1:0] rb [3];
	logic [DENW-1:0]      den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			dout_valid <= 1'b0;
		end else if (en) begin
			valid_s1   <= in_valid;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			valid_s4   <= valid_s3;
			dout_valid <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			v_s1[0] <= vel_x;
			v_s1[1] <= vel_y;
			v_s1[2] <= vel_z;
			pk_s1   <= push_factor * field_e;
			p_s1[0] <= push_factor * mag_x;
			p_s1[1] <= push_factor * mag_y;
			p_s1[2] <= push_factor * mag_z;
		end
	end

	always_comb begin
		// backward half step uses -k/2: one more fraction bit dropped
		kick_w = mode_s1 ? rnd_sh(-ext(pk_s1), FRAC + 1) : rnd_sh(ext(pk_s1), FRAC);
		for (int i = 0; i < 3; i++) begin
			t_w[i]   = mode_s1 ? rnd_sh(-ext(p_s1[i]), 17) : rnd_sh(ext(p_s1[i]), 16);
			t_sat[i] = sat32(t_w[i][SW-1:0]);
		end
		vmx_sat = sat32(SW'(v_s1[0]) + SW'($signed(kick_w[KW-1:0])));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s2   <= t_sat[0].ovf | t_sat[1].ovf | t_sat[2].ovf | vmx_sat.ovf;
			kick_s2  <= kick_w[KW-1:0];
			vm_s2[0] <= vmx_sat.val;
			vm_s2[1] <= v_s1[1];
			vm_s2[2] <= v_s1[2];
			for (int i = 0; i < 3; i++) begin
				t_s2[i] <= t_sat[i].val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s3  <= ovf_s2;
			kick_s3 <= kick_s2;
			for (int i = 0; i < 3; i++) begin
				vm_s3[i] <= vm_s2[i];
				t_s3[i]  <= t_s2[i];
				ca_s3[i] <= vm_s2[(i + 1) % 3] * t_s2[(i + 2) % 3];
				cb_s3[i] <= vm_s2[(i + 2) % 3] * t_s2[(i + 1) % 3];
				sq_s3[i] <= t_s2[i] * t_s2[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ra[i]     = rnd_sh(ext(ca_s3[i]), FRAC);
			rb[i]     = rnd_sh(ext(cb_s3[i]), FRAC);
			vo_sat[i] = sat32(SW'(vm_s3[i]) + ra[i][SW-1:0] - rb[i][SW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s4  <= ovf_s3 | vo_sat[0].ovf | vo_sat[1].ovf | vo_sat[2].ovf;
			kick_s4 <= kick_s3;
			sum_s4  <= $unsigned(sq_s3[0]) + $unsigned(sq_s3[1]) + $unsigned(sq_s3[2]);
			for (int i = 0; i < 3; i++) begin
				vm_s4[i]  <= vm_s3[i];
				vo_s4[i]  <= vo_sat[i].val;
				neg_s4[i] <= t_s3[i][DW-1];
				mag_s4[i] <= t_s3[i][DW-1] ? (~t_s3[i] + 1'b1) : t_s3[i];
			end
		end
	end

	assign den = DENW'(64'd1 << FRAC) + DENW'(sum_s4 >> FRAC);

	always_ff @(posedge clk) begin
		if (en) begin
			dout.den       <= den;
			dout.side.ovf  <= ovf_s4;
			dout.side.kick <= kick_s4;
			dout.side.vm   <= vm_s4;
			dout.side.vo   <= vo_s4;
			dout.side.neg  <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				dout.num[i] <= (NW'(mag_s4[i]) << 29) + NW'(den >> 1);
			end
		end
	end

endmodule

[rtl/bvp_div.sv]
module bvp_div import bvp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    din_valid,
	input  divin_t  din,
	output logic    dout_valid,
	output divout_t dout
);

	// one quotient bit per stage for all three components
	logic [DENW-1:0] rem_q [QW][3];
	logic [QW-1:0]   wrd_q [QW][3];
	logic [DENW-1:0] dv_q  [QW];
	side_t           sd_q  [QW];
	logic            vld_q [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [DENW-1:0] src_den;
		side_t           src_side;
		logic            src_vld;

		if (g == 0) begin : g_first
			assign src_den  = din.den;
			assign src_side = din.side;
			assign src_vld  = din_valid;
		end else begin : g_next
			assign src_den  = dv_q[g-1];
			assign src_side = sd_q[g-1];
			assign src_vld  = vld_q[g-1];
		end

		for (genvar u = 0; u < 3; u++) begin : g_unit
			logic [DENW-1:0] src_rem;
			logic [QW-1:0]   src_wrd;
			logic [DENW:0]   trial;
			logic [DENW:0]   diff;
			logic            fit;

			if (g == 0) begin : g_load
				assign src_rem = DENW'(din.num[u][NW-1:QW]);
				assign src_wrd = din.num[u][QW-1:0];
			end else begin : g_pass
				assign src_rem = rem_q[g-1][u];
				assign src_wrd = wrd_q[g-1][u];
			end

			assign trial = {src_rem, src_wrd[QW-1]};
			assign diff  = trial - {1'b0, src_den};
			assign fit   = trial >= {1'b0, src_den};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[g][u] <= fit ? diff[DENW-1:0] : trial[DENW-1:0];
					wrd_q[g][u] <= {src_wrd[QW-2:0], fit};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_q[g] <= src_den;
				sd_q[g] <= src_side;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= src_vld;
			end
		end
	end

	assign dout_valid = vld_q[QW-1];
	assign dout.side  = sd_q[QW-1];
	for (genvar u = 0; u < 3; u++) begin : g_out
		assign dout.quo[u] = wrd_q[QW-1][u];
	end

endmodule

[rtl/bvp_back.sv]
module bvp_back import bvp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 din_valid,
	input  divout_t              din,
	output logic                 out_valid,
	output logic signed [DW-1:0] new_vel_x,
	output logic signed [DW-1:0] new_vel_y,
	output logic signed [DW-1:0] new_vel_z,
	output logic                 overflow
);

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 ovf_s1, ovf_s2, ovf_s3;
	logic [KW-1:0]        kick_s1, kick_s2, kick_s3;
	logic signed [DW-1:0] vm_s1 [3];
	logic signed [DW-1:0] vo_s1 [3];
	logic signed [DW-1:0] s_s1 [3];
	logic signed [DW-1:0] vm_s2 [3];
	logic signed [PW-1:0] ca_s2 [3];
	logic signed [PW-1:0] cb_s2 [3];
	logic signed [DW-1:0] vp_s3 [3];

	logic signed [XW-1:0] ra [3];
	logic signed [XW-1:0] rb [3];
	sat_t                 vp_sat [3];
	sat_t                 fx_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= din_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			out_valid <= valid_s3;
		end
	end

	// restore the sign of s
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s1  <= din.side.ovf;
			kick_s1 <= din.side.kick;
			for (int i = 0; i < 3; i++) begin
				vm_s1[i] <= din.side.vm[i];
				vo_s1[i] <= din.side.vo[i];
				s_s1[i]  <= din.side.neg[i] ? -$signed(din.quo[i][DW-1:0])
					: $signed(din.quo[i][DW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s2  <= ovf_s1;
			kick_s2 <= kick_s1;
			for (int i = 0; i < 3; i++) begin
				vm_s2[i] <= vm_s1[i];
				ca_s2[i] <= vo_s1[(i + 1) % 3] * s_s1[(i + 2) % 3];
				cb_s2[i] <= vo_s1[(i + 2) % 3] * s_s1[(i + 1) % 3];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ra[i]     = rnd_sh(ext(ca_s2[i]), FRAC);
			rb[i]     = rnd_sh(ext(cb_s2[i]), FRAC);
			vp_sat[i] = sat32(SW'(vm_s2[i]) + ra[i][SW-1:0] - rb[i][SW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s3  <= ovf_s2 | vp_sat[0].ovf | vp_sat[1].ovf | vp_sat[2].ovf;
			kick_s3 <= kick_s2;
			for (int i = 0; i < 3; i++) begin
				vp_s3[i] <= vp_sat[i].val;
			end
		end
	end

	// second half kick on x
	assign fx_sat = sat32(SW'(vp_s3[0]) + SW'($signed(kick_s3)));

	always_ff @(posedge clk) begin
		if (en) begin
			new_vel_x <= fx_sat.val;
			new_vel_y <= vp_s3[1];
			new_vel_z <= vp_s3[2];
			overflow  <= ovf_s3 | fx_sat.ovf;
		end
	end

endmodule

[rtl/boris_velocity_push_core.sv]
// Boris velocity pusher, one particle per clock while no result is stalled. Each
// request carries a velocity, the x electric field and the magnetic field; the
// result is the pushed velocity in Q16.16 with a saturation flag. Stages: five
// front (field products, rotation vector t, first rotation and |t|^2), 33 of the
// bit-per-stage divider that forms s = 2t/(1+|t|^2), four back (second rotation
// and closing kick). A stall on the result side freezes the whole pipeline, so
// bubbles are not squeezed out. push_factor is to be written over the APB port
// while no request is in flight; the block does not enforce this. It reads back
// at address 0.
module boris_velocity_push_core import bvp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AW-1:0]        paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic signed [DW-1:0] vel_x,
	input  logic signed [DW-1:0] vel_y,
	input  logic signed [DW-1:0] vel_z,
	input  logic signed [DW-1:0] field_e,
	input  logic signed [DW-1:0] mag_x,
	input  logic signed [DW-1:0] mag_y,
	input  logic signed [DW-1:0] mag_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [DW-1:0] new_vel_x,
	output logic signed [DW-1:0] new_vel_y,
	output logic signed [DW-1:0] new_vel_z,
	output logic                 overflow
);

	logic signed [DW-1:0] push_factor_q;
	logic                 en;
	logic                 front_valid, div_valid;
	divin_t               front_out;
	divout_t              div_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_factor_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_PUSH_FACTOR) begin
			push_factor_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_PUSH_FACTOR) ? push_factor_q : '0;

	// hold every stage while the result waits
	assign en       = ~(out_valid & out_stall);
	assign in_stall = out_valid & out_stall;

	bvp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.mode        (mode),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.vel_z       (vel_z),
		.field_e     (field_e),
		.mag_x       (mag_x),
		.mag_y       (mag_y),
		.mag_z       (mag_z),
		.push_factor (push_factor_q),
		.dout_valid  (front_valid),
		.dout        (front_out)
	);

	bvp_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.din_valid  (front_valid),
		.din        (front_out),
		.dout_valid (div_valid),
		.dout       (div_out)
	);

	bvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.din_valid (div_valid),
		.din       (div_out),
		.out_valid (out_valid),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.new_vel_z (new_vel_z),
		.overflow  (overflow)
	);

endmodule

[rtl/bvp_checker.sv]
module bvp_checker import bvp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [AW-1:0]        paddr,
	input logic [31:0]          pwdata,
	input logic [31:0]          prdata,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic signed [DW-1:0] new_vel_x,
	input logic signed [DW-1:0] new_vel_y,
	input logic signed [DW-1:0] new_vel_z,
	input logic                 overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(new_vel_x) && $stable(new_vel_y)
			&& $stable(new_vel_z) && $stable(overflow))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("request side stalled without a waiting result");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == REG_PUSH_FACTOR
			|=> paddr[2] != REG_PUSH_FACTOR || prdata == $past(pwdata))
		else $error("push_factor readback mismatch");

endmodule

bind boris_velocity_push_core bvp_checker u_bvp_checker (.*);

[test/boris_push_checker.sv]
`timescale 1ns / 1ps
module boris_push_checker import bvp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [31:0]   factor,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 mode,
	input  logic signed [31:0]   vel_x,
	input  logic signed [31:0]   vel_y,
	input  logic signed [31:0]   vel_z,
	input  logic signed [31:0]   field_e,
	input  logic signed [31:0]   mag_x,
	input  logic signed [31:0]   mag_y,
	input  logic signed [31:0]   mag_z,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [31:0]   new_vel_x,
	input  logic signed [31:0]   new_vel_y,
	input  logic signed [31:0]   new_vel_z,
	input  logic                 overflow,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        ovf;
	} velocity_t;

	velocity_t expected_vel[$];

	function automatic longint clamp32(input longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// round half up, drop n bits; 128 bits so negation of a product cannot wrap
	function automatic longint round_shift(input logic signed [127:0] x, input int n);
		logic signed [127:0] r;
		r = (x + (128'sd1 <<< (n - 1))) >>> n;
		return longint'(r);
	endfunction

	function automatic velocity_t boris_push(input longint k, input logic md,
			input longint v[3], input longint e, input longint b[3]);
		velocity_t res;
		logic flag;
		longint kick, t[3], s[3], vm[3], vo[3], vp[3], fx;
		logic [63:0] sum, den, mag, q;
		logic signed [127:0] p;
		int j, m;
		flag = 1'b0;
		p = 128'(k) * 128'(e);
		kick = md ? round_shift(-p, 29) : round_shift(p, 28);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			p = 128'(k) * 128'(b[i]);
			t[i] = clamp32(md ? round_shift(-p, 17) : round_shift(p, 16), flag);
			sum += 64'(t[i] * t[i]);
		end
		den = (64'd1 << 28) + (sum >> 28);
		for (int i = 0; i < 3; i++) begin
			mag = t[i] < 0 ? 64'(-t[i]) : 64'(t[i]);
			q = ((mag << 29) + (den >> 1)) / den;
			s[i] = t[i] < 0 ? -longint'(q) : longint'(q);
		end
		vm[0] = clamp32(v[0] + kick, flag);
		vm[1] = v[1];
		vm[2] = v[2];
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			m = (i + 2) % 3;
			vo[i] = clamp32(vm[i] + round_shift(128'(vm[j]) * 128'(t[m]), 28)
				- round_shift(128'(vm[m]) * 128'(t[j]), 28), flag);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			m = (i + 2) % 3;
			vp[i] = clamp32(vm[i] + round_shift(128'(vo[j]) * 128'(s[m]), 28)
				- round_shift(128'(vo[m]) * 128'(s[j]), 28), flag);
		end
		fx = clamp32(vp[0] + kick, flag);
		res.vx = fx[31:0];
		res.vy = vp[1][31:0];
		res.vz = vp[2][31:0];
		res.ovf = flag;
		return res;
	endfunction

	assign pending = expected_vel.size();

	always @(posedge clk or negedge arst_n) begin
		velocity_t want;
		longint v[3], b[3];
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				v[0] = vel_x; v[1] = vel_y; v[2] = vel_z;
				b[0] = mag_x; b[1] = mag_y; b[2] = mag_z;
				expected_vel.push_back(boris_push(factor, mode, v, field_e, b));
			end
			if (out_valid && !out_stall) begin
				if (expected_vel.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h %h %h %b",
							new_vel_x, new_vel_y, new_vel_z, overflow);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_vel.pop_front();
					if (want.vx !== new_vel_x || want.vy !== new_vel_y
							|| want.vz !== new_vel_z || want.ovf !== overflow) begin
						if (fail_count < 10)
							$display("mismatch: expected %h %h %h %b, got %h %h %h %b",
								want.vx, want.vy, want.vz, want.ovf,
								new_vel_x, new_vel_y, new_vel_z, overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[test/tb_boris_velocity_push_core.sv]
`timescale 1ns / 1ps
module tb_boris_velocity_push_core import bvp_pkg::*;;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall, mode, overflow;
	logic signed [31:0] vel_x, vel_y, vel_z, field_e, mag_x, mag_y, mag_z;
	logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
	logic signed [31:0] factor;
	int fail_count, pending, cycle_count;
	int hold_off, send_idle_pct, recv_idle_pct;

	boris_velocity_push_core dut (.*);

	boris_push_checker checker_i (
		.clk, .arst_n, .factor, .in_valid, .in_stall, .mode, .vel_x, .vel_y,
		.vel_z, .field_e, .mag_x, .mag_y, .mag_z, .out_valid, .out_stall,
		.new_vel_x, .new_vel_y, .new_vel_z, .overflow, .fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(2000)) - 32'd1000;
			3: return $urandom;
			default: return 32'($signed($urandom) >>> $urandom_range(31, 8));
		endcase
	endfunction

	task automatic write_factor(input logic [31:0] k);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_PUSH_FACTOR, 2'b00}; pwdata <= k;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		factor <= k;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic send_request(input logic md, input logic [31:0] w[7]);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		{vel_x, vel_y, vel_z, field_e} <= {w[0], w[1], w[2], w[3]};
		{mag_x, mag_y, mag_z} <= {w[4], w[5], w[6]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	initial begin
		logic [31:0] w[7];
		logic [31:0] k_set[6];
		cycle_count = 0;
		arst_n = 1'b0;
		{psel, penable, pwrite, paddr, pwdata} = '0;
		{in_valid, mode, vel_x, vel_y, vel_z, field_e, mag_x, mag_y, mag_z} = '0;
		factor = 0;
		hold_off = 0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero factor at reset passes velocity through
		w = '{32'h7fffffff, 32'h80000000, 32'h12345, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h10000};
		send_request(1'b0, w);
		send_request(1'b1, w);
		drain();

		k_set = '{32'h7fffffff, 32'h80000000, 32'h00100000, 32'hfff00000,
			32'h00000001, 32'h01000000};
		foreach (k_set[p]) begin
			write_factor(k_set[p]);
			for (int d = 0; d < 4; d++) begin
				foreach (w[i]) w[i] = (d == 0) ? 32'h7fffffff :
					(d == 1) ? 32'h80000000 : (d == 2) ? 32'h0 : pick_word();
				send_request(d[0], w);
			end
			drain();
		end

		// random phases: idle, no idle, long hold-off
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(3))
				0: write_factor($urandom);
				1: write_factor(32'($signed($urandom) >>> $urandom_range(31, 4)));
				2: write_factor(32'($urandom_range(1, 64)) << 20);
				default: write_factor(phase[0] ? 32'h80000000 : 32'h7fffffff);
			endcase
			send_idle_pct = (phase == 2) ? 0 : 33;
			recv_idle_pct = (phase == 2) ? 0 : 33;
			if (phase == 4) hold_off = 300;
			for (int n = 0; n < 210; n++) begin
				foreach (w[i]) w[i] = pick_word();
				send_request($urandom_range(1), w);
			end
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[boris_velocity_push_core.f]
rtl/bvp_pkg.sv
rtl/bvp_front.sv
rtl/bvp_div.sv
rtl/bvp_back.sv
rtl/boris_velocity_push_core.sv
rtl/bvp_checker.sv
test/boris_push_checker.sv
test/tb_boris_velocity_push_core.sv
